>>> design/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master package
// Command codes, phase encoding and sizing defaults shared by the design files.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam int BUFFER_BYTES_DEF = 256;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_PUSH  = 2'd2;

  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_START1 = 10'b00_0000_0010,
    PH_ADDRW  = 10'b00_0000_0100,
    PH_REGHI  = 10'b00_0000_1000,
    PH_REGLO  = 10'b00_0001_0000,
    PH_DATA   = 10'b00_0010_0000,
    PH_START2 = 10'b00_0100_0000,
    PH_ADDRR  = 10'b00_1000_0000,
    PH_RX     = 10'b01_0000_0000,
    PH_STOP   = 10'b10_0000_0000
  } phase_t;

endpackage

>>> design/i2cram_in_if.sv
// ----------------------------------------------------------------------------
// I2C register access master command channel
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
interface i2cram_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic        sda_in;
  logic        is_read;
  logic [6:0]  dev_addr;
  logic        two_byte_addr;
  logic [15:0] reg_addr;
  logic [8:0]  byte_count;
  logic [7:0]  write_byte;

  modport source (
    output valid, cmd, sda_in, is_read, dev_addr, two_byte_addr, reg_addr, byte_count,
           write_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, sda_in, is_read, dev_addr, two_byte_addr, reg_addr, byte_count,
           write_byte,
    output ready
  );
endinterface

>>> design/i2cram_out_if.sv
// ----------------------------------------------------------------------------
// I2C register access master result channel
// Valid/ready channel carrying line levels and receive status per transfer.
// ----------------------------------------------------------------------------
interface i2cram_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_last;
  logic       busy_res;
  logic       done_res;

  modport source (
    output valid, scl, sda_out, sda_drive, rx_valid, rx_byte, rx_last, busy_res, done_res,
    input  ready
  );
  modport sink (
    input  valid, scl, sda_out, sda_drive, rx_valid, rx_byte, rx_last, busy_res, done_res,
    output ready
  );
endinterface

>>> design/i2c_register_access_master.sv
// ----------------------------------------------------------------------------
// I2C register access master
// Bit-level I2C master for register reads and writes, one pin change per tick.
// ----------------------------------------------------------------------------
// Usage: every transfer on in_ch produces exactly one transfer on out_ch.
// While idle, push appends write_byte to the write buffer if not full, and a
// begin command latches the device address, direction, register address and
// byte count. Each following tick command makes one change on SCL or SDA:
// start, address with write bit, register address byte(s), then either the
// data bytes from the buffer or a repeated start, address with read bit and
// the received bytes, and finally stop. Received bytes appear on rx_byte with
// rx_valid on the tick that samples their last bit; done_res marks the end of
// stop. Commands other than tick are ignored while a transaction runs.
// Each result is registered and offered in the next cycle. One item is
// accepted every cycle; the output register frees its slot when out_ch takes
// the result, so a stalled receiver holds in_ch through ready. The write
// buffer is a RAM read at the buffer pointer; the byte at a new pointer is on
// the read port in the cycle after the pointer moves, before the second
// tick of the data phase, which drives its first bit. Reset leaves the
// master idle with both lines high, SDA driven and the buffer empty.
// ----------------------------------------------------------------------------
module i2c_register_access_master #(
  parameter int BUFFER_BYTES = i2cram_pkg::BUFFER_BYTES_DEF
) (
  input logic         clk,
  input logic         rst,
  i2cram_in_if.sink   in_ch,
  i2cram_out_if.source out_ch
);

  localparam int AW     = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

  i2cram_pkg::phase_t phase, phase_next;
  logic [4:0]        bit_step, bit_step_next;
  logic [1:0]        sub_step, sub_step_next;
  logic [2:0]        bit_idx, bit_idx_next;
  logic [8:0]        bytes_left, bytes_left_next;
  logic [8:0]        bytes_dec;
  logic [7:0]        shift_reg, shift_reg_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic              req_read, req_two;
  logic [6:0]        req_dev;
  logic [15:0]       req_reg;
  logic              scl, scl_next;
  logic              sda, sda_next;
  logic              drive, drive_next;
  logic              rxv, rxl, done, step_end;
  logic              ram_we;
  logic [7:0]        ram_rd_data;
  logic [7:0]        tx_byte;
  logic              in_fire;
  logic              begin_cmd;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign begin_cmd   = in_fire && (phase == i2cram_pkg::PH_IDLE)
                       && (in_ch.cmd == i2cram_pkg::CMD_BEGIN);
  assign bytes_dec   = (bytes_left != 9'd0) ? bytes_left - 9'd1 : bytes_left;

  i2cram_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_buf (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(AW'(fill)),
    .wr_data(in_ch.write_byte),
    .rd_addr(ptr),
    .rd_data(ram_rd_data)
  );

  always_comb begin
    unique case (phase)
      i2cram_pkg::PH_ADDRW: tx_byte = {req_dev, 1'b0};
      i2cram_pkg::PH_ADDRR: tx_byte = {req_dev, 1'b1};
      i2cram_pkg::PH_REGHI: tx_byte = req_reg[15:8];
      i2cram_pkg::PH_REGLO: tx_byte = req_reg[7:0];
      default:              tx_byte = ram_rd_data;
    endcase
  end

  always_comb begin
    phase_next      = phase;
    bit_step_next   = bit_step;
    sub_step_next   = sub_step;
    bit_idx_next    = bit_idx;
    bytes_left_next = bytes_left;
    shift_reg_next  = shift_reg;
    ptr_next        = ptr;
    fill_next       = fill;
    scl_next        = scl;
    sda_next        = sda;
    drive_next      = drive;
    rxv             = 1'b0;
    rxl             = 1'b0;
    done            = 1'b0;
    step_end        = 1'b0;
    ram_we          = 1'b0;

    if (in_fire) begin
      if (phase == i2cram_pkg::PH_IDLE) begin
        if (in_ch.cmd == i2cram_pkg::CMD_BEGIN) begin
          bytes_left_next = in_ch.byte_count;
          ptr_next        = '0;
          bit_step_next   = '0;
          sub_step_next   = '0;
          bit_idx_next    = '0;
          phase_next      = i2cram_pkg::PH_START1;
        end else if (in_ch.cmd == i2cram_pkg::CMD_PUSH
                     && fill < FILL_W'(BUFFER_BYTES)) begin
          ram_we    = 1'b1;
          fill_next = fill + FILL_W'(1);
        end
      end else if (in_ch.cmd == i2cram_pkg::CMD_TICK) begin
        unique case (phase)
          i2cram_pkg::PH_START1, i2cram_pkg::PH_START2: begin
            unique case (bit_step)
              5'd0:    sda_next = 1'b1;
              5'd1:    scl_next = 1'b1;
              5'd2:    sda_next = 1'b0;
              default: begin
                scl_next = 1'b0;
                step_end = 1'b1;
              end
            endcase
          end
          i2cram_pkg::PH_RX: begin
            if (bit_step == 5'd0) begin
              drive_next     = 1'b0;
              shift_reg_next = '0;
            end else if (bit_step <= 5'd16) begin
              if (bit_step[0]) begin
                scl_next = 1'b0;
              end else begin
                scl_next       = 1'b1;
                shift_reg_next = {shift_reg[6:0], in_ch.sda_in};
                if (bit_step == 5'd16) begin
                  rxv = 1'b1;
                  rxl = (bytes_left == 9'd1);
                end
              end
            end else if (bit_step == 5'd17) begin
              scl_next = 1'b0;
            end else if (bit_step == 5'd18) begin
              drive_next = 1'b1;
            end else if (bit_step == 5'd19) begin
              sda_next = !(bytes_left > 9'd1);
            end else if (bit_step == 5'd20) begin
              scl_next = 1'b1;
            end else begin
              scl_next = 1'b0;
              step_end = 1'b1;
            end
          end
          i2cram_pkg::PH_STOP: begin
            unique case (bit_step)
              5'd0:    scl_next = 1'b0;
              5'd1:    sda_next = 1'b0;
              5'd2:    scl_next = 1'b1;
              default: begin
                sda_next = 1'b1;
                step_end = 1'b1;
              end
            endcase
          end
          default: begin
            if (bit_step < 5'd24) begin
              unique case (sub_step)
                2'd0:    scl_next = 1'b0;
                2'd1:    sda_next = tx_byte[3'd7 - bit_idx];
                default: begin
                  scl_next     = 1'b1;
                  bit_idx_next = bit_idx + 3'd1;
                end
              endcase
              sub_step_next = (sub_step == 2'd2) ? 2'd0 : sub_step + 2'd1;
            end else if (bit_step == 5'd24) begin
              scl_next = 1'b0;
            end else if (bit_step == 5'd25) begin
              sda_next = 1'b1;
            end else if (bit_step == 5'd26) begin
              scl_next = 1'b1;
            end else begin
              scl_next = 1'b0;
              step_end = 1'b1;
            end
          end
        endcase

        if (step_end) begin
          bit_step_next = '0;
          sub_step_next = '0;
          bit_idx_next  = '0;
          unique case (phase)
            i2cram_pkg::PH_START1: phase_next = i2cram_pkg::PH_ADDRW;
            i2cram_pkg::PH_ADDRW:
              phase_next = req_two ? i2cram_pkg::PH_REGHI : i2cram_pkg::PH_REGLO;
            i2cram_pkg::PH_REGHI:  phase_next = i2cram_pkg::PH_REGLO;
            i2cram_pkg::PH_REGLO: begin
              if (req_read) begin
                phase_next = i2cram_pkg::PH_START2;
              end else begin
                phase_next = (bytes_left != 9'd0) ? i2cram_pkg::PH_DATA
                                                  : i2cram_pkg::PH_STOP;
              end
            end
            i2cram_pkg::PH_DATA: begin
              bytes_left_next = bytes_dec;
              ptr_next = (ptr == AW'(BUFFER_BYTES - 1)) ? '0 : ptr + AW'(1);
              phase_next = (bytes_dec != 9'd0) ? i2cram_pkg::PH_DATA
                                               : i2cram_pkg::PH_STOP;
            end
            i2cram_pkg::PH_START2: phase_next = i2cram_pkg::PH_ADDRR;
            i2cram_pkg::PH_ADDRR:
              phase_next = (bytes_left != 9'd0) ? i2cram_pkg::PH_RX : i2cram_pkg::PH_STOP;
            i2cram_pkg::PH_RX: begin
              bytes_left_next = bytes_dec;
              phase_next = (bytes_dec != 9'd0) ? i2cram_pkg::PH_RX : i2cram_pkg::PH_STOP;
            end
            default: begin
              phase_next = i2cram_pkg::PH_IDLE;
              fill_next  = '0;
              ptr_next   = '0;
              done       = 1'b1;
            end
          endcase
        end else begin
          bit_step_next = bit_step + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cram_pkg::PH_IDLE;
      bit_step   <= '0;
      sub_step   <= '0;
      bit_idx    <= '0;
      bytes_left <= '0;
      ptr        <= '0;
      fill       <= '0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      drive      <= 1'b1;
      out_ch.valid <= 1'b0;
    end else begin
      phase      <= phase_next;
      bit_step   <= bit_step_next;
      sub_step   <= sub_step_next;
      bit_idx    <= bit_idx_next;
      bytes_left <= bytes_left_next;
      ptr        <= ptr_next;
      fill       <= fill_next;
      scl        <= scl_next;
      sda        <= sda_next;
      drive      <= drive_next;
      if (in_fire) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_reg <= shift_reg_next;
    if (begin_cmd) begin
      req_read <= in_ch.is_read;
      req_two  <= in_ch.two_byte_addr;
      req_dev  <= in_ch.dev_addr;
      req_reg  <= in_ch.reg_addr;
    end
    if (in_fire) begin
      out_ch.scl       <= scl_next;
      out_ch.sda_out   <= sda_next;
      out_ch.sda_drive <= drive_next;
      out_ch.rx_valid  <= rxv;
      out_ch.rx_byte   <= rxv ? shift_reg_next : 8'd0;
      out_ch.rx_last   <= rxl;
      out_ch.busy_res  <= (phase_next != i2cram_pkg::PH_IDLE);
      out_ch.done_res  <= done;
    end
  end

  a_rx_released: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.rx_valid |-> !out_ch.sda_drive)
    else $error("received byte reported while SDA is driven");

  a_idle_ptr: assert property (@(posedge clk) disable iff (rst)
    phase == i2cram_pkg::PH_IDLE |-> ptr == '0)
    else $error("buffer pointer not cleared while idle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && done |=> phase == i2cram_pkg::PH_IDLE && fill == '0)
    else $error("stop finished but master not idle with empty buffer");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == i2cram_pkg::PH_DATA || phase == i2cram_pkg::PH_RX |-> bytes_left != 9'd0)
    else $error("data phase entered with no bytes left");

  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase != i2cram_pkg::PH_IDLE && in_ch.cmd != i2cram_pkg::CMD_TICK
    |=> $stable(phase) && $stable(bit_step) && $stable(scl) && $stable(sda))
    else $error("non-tick command changed a running transaction");

endmodule

>>> design/i2cram_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module i2cram_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
